// ===== rtl/core/wmd_pkg.sv =====
// Shared widths, reset values and control types for the windowed mean/deviation block.
package wmd_pkg;

  localparam int SAMPLE_W       = 16;
  localparam int MEAN_W         = 16;
  localparam int DEV_W          = 24;
  localparam int HW_W           = 7;
  localparam int WMD_WINDOW_LEN = 128;

  localparam logic [HW_W-1:0] HW_RESET = 7'd32;

  // Controls for one serial divider
  typedef struct packed {
    logic load;  // take in dividend and divisor
    logic step;  // retire one quotient bit
  } wmd_div_ctl_t;

endpackage

// ===== rtl/core/wmd_in_if.sv =====
// Input channel: one power sample per item.
interface wmd_in_if
  import wmd_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// ===== rtl/core/wmd_out_if.sv =====
// Result channel: mean, signed deviation and window-full flag per item.
interface wmd_out_if
  import wmd_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [MEAN_W-1:0]        mean;
  logic signed [DEV_W-1:0]  deviation;
  logic                     window_full;

  modport source (output valid, output mean, output deviation, output window_full,
                  input ready);
  modport sink   (input valid, input mean, input deviation, input window_full,
                  output ready);
endinterface

// ===== rtl/core/windowed_mean_deviation.sv =====
// Top level: windowed mean and scaled deviation of a power sample stream.
//
//   channel   dir   handshake        payload
//   in_ch     in    valid / ready    sample[15:0]
//   out_ch    out   valid / ready    mean[15:0], deviation[23:0] signed, window_full
//   cfg       in    cfg_we           cfg_wdata[6:0] = half_width
//
// One item at a time: accept, ring update, then PROD_W serial divide steps and
// HW_W shift-add multiply steps. The bit-serial divider accounts for most of those steps.
// Reset clears sum, write slot, fill flag, sets half_width to HW_RESET; ring entries
// not yet written read as zero through the fill flag, so no clearing pass is run.
// A finished result waits in the output register while the next item is taken.
module windowed_mean_deviation
  import wmd_pkg::*;
#(
  parameter int WINDOW_LEN = WMD_WINDOW_LEN
) (
  input  logic            clk,
  input  logic            rst_n,
  wmd_in_if.sink          in_ch,
  wmd_out_if.source       out_ch,
  input  logic            cfg_we,
  input  logic [HW_W-1:0] cfg_wdata
);

  localparam int IDX_W  = $clog2(WINDOW_LEN);
  localparam int SUM_W  = SAMPLE_W + IDX_W;
  localparam int PROD_W = SUM_W + HW_W;
  localparam int DVS_W  = $clog2(WINDOW_LEN + 1);
  localparam int CNT_W  = $clog2(PROD_W + 1);
  localparam int DIFF_W = SAMPLE_W + 1;

  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(WINDOW_LEN - 1);
  localparam logic [DVS_W-1:0] WIN_DVS   = DVS_W'(WINDOW_LEN);
  localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(PROD_W - 1);
  localparam logic [CNT_W-1:0] MUL_LAST  = CNT_W'(HW_W - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPD,
    S_DLD,
    S_DIV,
    S_MSET,
    S_MUL,
    S_FIN
  } state_t;

  state_t              state_r;
  logic [SAMPLE_W-1:0] samp_r;
  logic [SUM_W-1:0]    sum_r;
  logic [IDX_W-1:0]    slot_r;
  logic                filled_r;
  logic                mode_full_r;
  logic [HW_W-1:0]     hw_r;
  logic [DVS_W-1:0]    dvs_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [PROD_W-1:0]   mcand_a_r, acc_a_r;
  logic [DEV_W-1:0]    mcand_b_r, acc_b_r;
  logic [HW_W-1:0]     mplr_r;
  logic                out_valid_r;
  logic [MEAN_W-1:0]   mean_r;
  logic [DEV_W-1:0]    dev_r;
  logic                full_r;

  logic [SAMPLE_W-1:0] ring_rdata;
  logic [SAMPLE_W-1:0] old_samp;
  logic [SUM_W-1:0]    sum_nxt;
  logic [PROD_W-1:0]   quo_a, quo_b;
  logic [DIFF_W-1:0]   diff;
  logic [DEV_W-1:0]    dev_nxt;
  logic                out_free;
  logic                in_take;
  wmd_div_ctl_t        div_ctl;

  // Sample ring; the read port always points at the slot about to be replaced
  wmd_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (WINDOW_LEN)
  ) u_ring (
    .clk   (clk),
    .we    (state_r == S_UPD),
    .waddr (slot_r),
    .wdata (samp_r),
    .raddr (slot_r),
    .rdata (ring_rdata)
  );

  // Two serial dividers: mean and, once full, the scaled sum
  assign div_ctl.load = (state_r == S_DLD);
  assign div_ctl.step = (state_r == S_DIV);

  wmd_sdiv #(
    .DVD_W (PROD_W),
    .DVS_W (DVS_W)
  ) u_div_mean (
    .clk      (clk),
    .ctl      (div_ctl),
    .dividend (PROD_W'(sum_r)),
    .divisor  (dvs_r),
    .quotient (quo_a)
  );

  wmd_sdiv #(
    .DVD_W (PROD_W),
    .DVS_W (DVS_W)
  ) u_div_scaled (
    .clk      (clk),
    .ctl      (div_ctl),
    .dividend (acc_a_r),
    .divisor  (WIN_DVS),
    .quotient (quo_b)
  );

  // Datapath helpers
  always_comb begin
    old_samp = filled_r ? ring_rdata : '0;
    sum_nxt  = sum_r - SUM_W'(old_samp) + SUM_W'(samp_r);
    diff     = {1'b0, samp_r} - {1'b0, quo_a[MEAN_W-1:0]};
    dev_nxt  = mode_full_r ? (acc_b_r - quo_b[DEV_W-1:0]) : acc_a_r[DEV_W-1:0];
    out_free = !out_valid_r || out_ch.ready;
    in_take  = in_ch.valid && (state_r == S_IDLE);
  end

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.mean        = mean_r;
  assign out_ch.deviation   = dev_r;
  assign out_ch.window_full = full_r;

  // Sequencer, datapath and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sum_r       <= '0;
      slot_r      <= '0;
      filled_r    <= 1'b0;
      hw_r        <= HW_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        hw_r <= cfg_wdata;
      end

      // S_FIN reloads the output register itself
      if (out_valid_r && out_ch.ready && state_r != S_FIN) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_take) begin
            samp_r  <= in_ch.sample;
            state_r <= S_UPD;
          end
        end

        // replace the oldest entry, choose this item's divisor and mode
        S_UPD: begin
          sum_r       <= sum_nxt;
          mode_full_r <= filled_r;
          dvs_r       <= filled_r ? WIN_DVS : (DVS_W'(slot_r) + DVS_W'(1));
          if (!filled_r && slot_r == LAST_SLOT) begin
            filled_r <= 1'b1;
          end
          slot_r  <= (slot_r == LAST_SLOT) ? '0 : slot_r + IDX_W'(1);
          state_r <= filled_r ? S_MSET : S_DLD;
        end

        S_DLD: begin
          cnt_r   <= '0;
          state_r <= S_DIV;
        end

        S_DIV: begin
          cnt_r <= cnt_r + CNT_W'(1);
          if (cnt_r == DIV_LAST) begin
            state_r <= mode_full_r ? S_FIN : S_MSET;
          end
        end

        // full: sum*hw and sample*hw; filling: (sample - mean)*hw
        S_MSET: begin
          mcand_a_r <= mode_full_r ? PROD_W'(sum_r)
                                   : {{(PROD_W-DIFF_W){diff[DIFF_W-1]}}, diff};
          mcand_b_r <= DEV_W'(samp_r);
          mplr_r    <= hw_r;
          acc_a_r   <= '0;
          acc_b_r   <= '0;
          cnt_r     <= '0;
          state_r   <= S_MUL;
        end

        S_MUL: begin
          if (mplr_r[0]) begin
            acc_a_r <= acc_a_r + mcand_a_r;
            acc_b_r <= acc_b_r + mcand_b_r;
          end
          mcand_a_r <= {mcand_a_r[PROD_W-2:0], 1'b0};
          mcand_b_r <= {mcand_b_r[DEV_W-2:0], 1'b0};
          mplr_r    <= {1'b0, mplr_r[HW_W-1:1]};
          cnt_r     <= cnt_r + CNT_W'(1);
          if (cnt_r == MUL_LAST) begin
            state_r <= mode_full_r ? S_DLD : S_FIN;
          end
        end

        // hand the item to the output register once it is free
        S_FIN: begin
          if (out_free) begin
            mean_r      <= quo_a[MEAN_W-1:0];
            dev_r       <= dev_nxt;
            full_r      <= filled_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  // once the window has filled it stays full
  a_filled_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !$fell(filled_r))
    else $error("window-full flag dropped");

  // the window fills exactly as the write slot wraps
  a_fill_on_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(filled_r) |-> (slot_r == '0))
    else $error("window filled away from slot wrap");

  // a finished mean always fits the mean field
  a_mean_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) |-> (quo_a[PROD_W-1:MEAN_W] == '0))
    else $error("mean quotient overflows field");
`endif

endmodule

// ===== rtl/core/wmd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module wmd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/wmd_sdiv.sv =====
// Restoring serial divider: one quotient bit per step, dividend shifted out MSB first.
module wmd_sdiv
  import wmd_pkg::*;
#(
  parameter int DVD_W = 30,
  parameter int DVS_W = 8
) (
  input  logic             clk,
  input  wmd_div_ctl_t     ctl,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic [DVD_W-1:0] quotient
);

  logic [DVD_W-1:0] quo_r, quo_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W-1:0] dvs_r;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             ge;

  // Shift in the next dividend bit and try a subtract
  always_comb begin
    trial   = {rem_r, quo_r[DVD_W-1]};
    diff    = trial - {1'b0, dvs_r};
    ge      = (trial >= {1'b0, dvs_r});
    rem_nxt = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
    quo_nxt = {quo_r[DVD_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (ctl.step) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quotient = quo_r;

endmodule
